// ===== design/psfo_pkg.sv =====
// shared types and constants of the phase shaped fold oscillator
// fixed point constants are Q.28 integers; no dependencies
package psfo_pkg;

	localparam int FRAC = 28;
	localparam int DIV_QBITS = 32;

	localparam logic signed [31:0] ONE = 32'sd268435456;
	localparam logic signed [31:0] PAD_C1 = 32'sd1686629713;
	localparam logic signed [35:0] PAD_C3 = 36'sd8911691981;
	localparam logic signed [35:0] PAD_C5 = 36'sd8708559890;
	localparam logic signed [35:0] PAD_D2 = 36'sd347894675;
	localparam logic signed [35:0] PAD_D4 = 36'sd188658397;
	localparam logic signed [31:0] K049 = 32'sd131533373;
	localparam logic signed [30:0] K051 = 31'sd136902083;
	localparam logic signed [31:0] A999 = 32'sd268167021;
	localparam logic signed [31:0] FOLD_SLOPE = 32'sd9110627;
	localparam logic [31:0] FOLD_BASE = 32'd1065353217;
	localparam logic [30:0] BENT_MAX = 31'h7FFFFFFF;

	typedef enum logic [4:0] {
		OP_CODE, OP_X2, OP_X3, OP_X4, OP_X5, OP_T1, OP_T3, OP_T5, OP_E1, OP_E2,
		OP_DIV1, OP_S, OP_A, OP_N2, OP_E3, OP_DIV2, OP_F, OP_V, OP_OUT
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		logic wb_en;
		logic div_start;
		logic div_wb;
		logic out_load;
		op_t  op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} ctrl_sts_t;

endpackage

// ===== design/psfo_div.sv =====
// unsigned restoring divider, two quotient bits per cycle
// quotient of num * 2^28 / den; needs num < 16 * den; uses psfo_pkg
module psfo_div import psfo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [35:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);

	localparam int STEPS = DIV_QBITS / 2;
	localparam int CW = $clog2(STEPS);

	logic [31:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [31:0] r1, r2;
	logic q1, q2;

	function automatic logic [32:0] dstep(input logic [31:0] r, input logic b,
			input logic [31:0] v);
		logic [32:0] t;
		t = {r, b};
		if (t >= {1'b0, v})
			return {t[31:0] - v, 1'b1};
		return {t[31:0], 1'b0};
	endfunction

	always_comb begin
		{r1, q1} = dstep(rem_q, quo_q[31], den_q);
		{r2, q2} = dstep(r1, quo_q[30], den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[35:4];
			quo_q <= {num[3:0], 28'd0};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= {quo_q[29:0], q1, q2};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("divider done without run");
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start)) else $error("divider busy without start");

endmodule

// ===== design/psfo_dp.sv =====
// datapath: phase accumulator, shared multiplier, divider and output register
// driven by psfo_ctrl commands; uses psfo_pkg and psfo_div
module psfo_dp import psfo_pkg::*; #(
	parameter int PHASE_BITS = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctrl_cmd_t                     cmd,
	output ctrl_sts_t                     sts,
	input  logic [30:0]                   phase_step,
	input  logic [15:0]                   bend_amount,
	input  logic [15:0]                   fold_exponent,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	localparam int RSH = FRAC + 1 - SAMPLE_BITS;
	localparam int RW = 30 - RSH;

	logic [PHASE_BITS-1:0] phase_q;
	logic [15:0] bend_q, fexp_q;
	logic [FRAC+PHASE_BITS-1:0] pext;
	logic [FRAC-1:0] p;
	logic signed [27:0] x, x2_q, x3_q, x4_q, x5_q, d;
	logic signed [33:0] num_q;
	logic signed [31:0] den_q;
	logic signed [32:0] pade_q;
	logic signed [30:0] s_q, den2_q;
	logic [27:0] a_q, f_q;
	logic signed [29:0] num2_q, v_q;
	logic [30:0] bent_q;
	logic [3:0] e_q;
	logic [22:0] m_q;
	logic num_neg_q, sat_q;
	logic signed [35:0] ma;
	logic signed [31:0] mb;
	logic signed [67:0] prod_s1, sh;
	logic [31:0] code;
	logic [70:0] fsh;
	logic [33:0] num_mag;
	logic [31:0] den_c, den2_c;
	logic [35:0] div_num;
	logic [31:0] div_den, quo;
	logic div_done;
	logic signed [28:0] d_w;
	logic signed [RW-1:0] r;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	assign pext = {phase_q, FRAC'(0)};
	assign p = pext[FRAC+PHASE_BITS-1 -: FRAC];
	assign x = $signed({~p[FRAC-1], p[FRAC-2:0]});
	assign d_w = f_q[27] ? $signed({1'b0, f_q}) - 29'sd201326592
		: $signed({1'b0, f_q}) - 29'sd67108864;
	assign d = 28'(d_w);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_CODE: begin ma = $signed({20'd0, fexp_q}); mb = FOLD_SLOPE; end
			OP_X2: begin ma = 36'(x); mb = 32'(x); end
			OP_X3: begin ma = 36'(x2_q); mb = 32'(x); end
			OP_X4: begin ma = 36'(x2_q); mb = 32'(x2_q); end
			OP_X5: begin ma = 36'(x2_q); mb = 32'(x3_q); end
			OP_T1: begin ma = 36'(x); mb = PAD_C1; end
			OP_T3: begin ma = PAD_C3; mb = 32'(x3_q); end
			OP_T5: begin ma = PAD_C5; mb = 32'(x5_q); end
			OP_E1: begin ma = PAD_D2; mb = 32'(x2_q); end
			OP_E2: begin ma = PAD_D4; mb = 32'(x4_q); end
			OP_S: begin ma = 36'(pade_q); mb = K049; end
			OP_A: begin ma = $signed({20'd0, bend_q}); mb = A999; end
			OP_N2: begin ma = 36'(s_q); mb = ONE - $signed({4'd0, a_q}); end
			OP_E3: begin
				ma = 36'(ONE) - (36'(s_q) <<< 1);
				mb = $signed({4'd0, a_q});
			end
			OP_F: begin ma = $signed({12'd0, 1'b1, m_q}); mb = $signed({1'b0, bent_q}); end
			OP_V: begin ma = 36'(d); mb = 32'(d); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign sh = prod_s1 >>> FRAC;
	assign code = prod_s1[44:13] + FOLD_BASE;
	assign fsh = {16'd0, prod_s1[54:0]} << e_q;
	assign num_mag = num_q[33] ? 34'(-num_q) : 34'(num_q);
	assign den_c = (den_q < 32'sd1) ? 32'd1 : den_q;
	assign den2_c = (den2_q < 31'sd1) ? 32'd1 : {1'b0, den2_q};

	always_comb begin
		if (cmd.op == OP_DIV1) begin
			div_num = {2'd0, num_mag};
			div_den = den_c;
		end else begin
			div_num = {6'd0, num2_q};
			div_den = den2_c;
		end
	end

	psfo_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (quo)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.load) begin
			phase_q <= phase_q + PHASE_BITS'({{PHASE_BITS{1'b0}}, phase_step});
		end
	end

	always_comb begin
		r = RW'(v_q >>> RSH);
		if (r > RW'((1 << (SAMPLE_BITS - 1)) - 1))
			r = RW'((1 << (SAMPLE_BITS - 1)) - 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bend_q <= bend_amount;
			fexp_q <= fold_exponent;
		end
		if (cmd.mul_en)
			prod_s1 <= ma * mb;
		if (cmd.wb_en) begin
			case (cmd.op)
				OP_CODE: begin e_q <= code[26:23] + 4'd1; m_q <= code[22:0]; end
				OP_X2: x2_q <= 28'(sh);
				OP_X3: x3_q <= 28'(sh);
				OP_X4: x4_q <= 28'(sh);
				OP_X5: x5_q <= 28'(sh);
				OP_T1: num_q <= -34'(sh);
				OP_T3: num_q <= num_q + 34'(sh);
				OP_T5: num_q <= num_q - 34'(sh);
				OP_E1: den_q <= ONE + 32'(sh);
				OP_E2: den_q <= den_q + 32'(sh);
				OP_S: s_q <= 31'(sh) + K051;
				OP_A: a_q <= prod_s1[43:16];
				OP_N2: num2_q <= (sh < 0) ? 30'sd0 : 30'(sh);
				OP_E3: den2_q <= 31'(ONE) + 31'(sh);
				OP_F: f_q <= fsh[50:23];
				OP_V: v_q <= f_q[27] ? 30'(prod_s1[52:24]) - 30'(ONE)
					: 30'(ONE) - 30'(prod_s1[52:24]);
				default: ;
			endcase
		end
		if (cmd.div_start) begin
			num_neg_q <= num_q[33];
			sat_q <= {4'd0, num2_q} >= {den2_c[30:0], 3'd0};
		end
		if (cmd.div_wb) begin
			if (cmd.op == OP_DIV1)
				pade_q <= num_neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
			else
				bent_q <= sat_q ? BENT_MAX : quo[30:0];
		end
		if (cmd.out_load)
			sample_q <= SAMPLE_BITS'(r);
	end

	assign sample = sample_q;

endmodule

// ===== design/psfo_ctrl.sv =====
// controller: walks the operation sequence and runs both handshakes
// drives psfo_dp through ctrl_cmd_t; uses psfo_pkg
module psfo_ctrl import psfo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_ISSUE  = 6'b000010,
		ST_WB     = 6'b000100,
		ST_DSTART = 6'b001000,
		ST_DWAIT  = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	op_t op_q, op_d, op_nx;
	logic out_valid_q;
	logic can_load;

	assign op_nx = op_t'(op_q + 5'd1);
	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		cmd = '0;
		cmd.op = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d = OP_CODE;
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.mul_en = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb_en = 1'b1;
				op_d = op_nx;
				if (op_nx == OP_DIV1 || op_nx == OP_DIV2)
					state_d = ST_DSTART;
				else if (op_nx == OP_OUT)
					state_d = ST_OUT;
				else
					state_d = ST_ISSUE;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (sts.div_done) begin
					cmd.div_wb = 1'b1;
					op_d = op_nx;
					state_d = ST_ISSUE;
				end
			end
			ST_OUT: begin
				if (can_load) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_CODE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== design/phase_shaped_fold_oscillator.sv =====
// channel | signals                                         | transfer when
// in      | in_valid, in_stall, phase_step, bend_amount,    | in_valid && !in_stall
//         | fold_exponent                                   |
// out     | out_valid, out_stall, sample                    | out_valid && !out_stall
// one item takes the input transfer, 16 multiplies on the shared multiplier (an issue state and a
// write-back state each), two divides on the divider and the output load
// the next item is taken as soon as the result is in the output register
// reset clears the phase accumulator and all handshake state
// a stalled output holds the block after the next item is computed
module phase_shaped_fold_oscillator import psfo_pkg::*; #(
	parameter int PHASE_BITS = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [30:0]                   phase_step,
	input  logic [15:0]                   bend_amount,
	input  logic [15:0]                   fold_exponent,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	psfo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	psfo_dp #(
		.PHASE_BITS (PHASE_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.phase_step   (phase_step),
		.bend_amount  (bend_amount),
		.fold_exponent(fold_exponent),
		.sample       (sample)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("idle right after input transfer");
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall)) else $error("result without work");
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid) else $error("returned idle without result");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of the phase shaped fold oscillator
// computes each expected sample itself and compares every output transfer; depends on psfo_pkg
`timescale 1ns / 1ps

module testbench import psfo_pkg::*;;

	localparam int PB = 32;
	localparam int SB = 16;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [30:0] phase_step = '0;
	logic [15:0] bend_amount = '0;
	logic [15:0] fold_exponent = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SB-1:0] sample;

	logic [PB-1:0] osc_phase;
	logic signed [SB-1:0] sample_queue[$];
	int errors = 0;
	int samples_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	phase_shaped_fold_oscillator #(.PHASE_BITS(PB), .SAMPLE_BITS(SB)) u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint asr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint mq(longint a, longint b);
		return (a * b) >>> FRAC;
	endfunction

	// advances the phase and returns the expected sample
	function automatic logic signed [SB-1:0] osc_sample(logic [30:0] stp, logic [15:0] bnd,
			logic [15:0] fex);
		longint one, p, x, x2, x3, x4, x5, num, den, pade, s, a, num2, den2, bent, v, r, d;
		longint unsigned code, e, m, prod, f;
		one = longint'(1) << FRAC;
		osc_phase = osc_phase + PB'(stp);
		p = longint'(osc_phase >> (PB - FRAC));
		x = p - one / 2;
		x2 = mq(x, x);
		x3 = mq(x2, x);
		x4 = mq(x2, x2);
		x5 = mq(x2, x3);
		num = -mq(PAD_C1, x) + mq(PAD_C3, x3) - mq(PAD_C5, x5);
		den = one + mq(PAD_D2, x2) + mq(PAD_D4, x4);
		if (den < 1) den = 1;
		pade = (num * one) / den;
		s = asr(pade * K049, FRAC) + K051;
		a = longint'((longint'(bnd) * A999) >> 16);
		num2 = mq(s, one - a);
		den2 = one + mq(a, one - 2 * s);
		if (den2 < 1) den2 = 1;
		if (num2 < 0) num2 = 0;
		bent = (num2 * one) / den2;
		if (bent > 64'h7FFFFFFF) bent = 64'h7FFFFFFF;
		code = ((longint'(fex) * FOLD_SLOPE) >> 13) + FOLD_BASE;
		e = ((code >> 23) - 127) & 15;
		m = code & 64'h7FFFFF;
		prod = longint'(bent) * ((longint'(1) << 23) + m);
		f = ((prod << e) >> 23) & (one - 1);
		if (f < (one >> 1)) begin
			d = longint'(f) - (one >> 2);
			v = one - longint'(longint'(d * d) >> (FRAC - 4));
		end else begin
			d = longint'(f) - 3 * (one >> 2);
			v = longint'(longint'(d * d) >> (FRAC - 4)) - one;
		end
		r = asr(v, FRAC + 1 - SB);
		if (r > (longint'(1) << (SB - 1)) - 1) r = (longint'(1) << (SB - 1)) - 1;
		if (r < -(longint'(1) << (SB - 1))) r = -(longint'(1) << (SB - 1));
		return SB'(r);
	endfunction

	task automatic send_tick(logic [30:0] stp, logic [15:0] bnd, logic [15:0] fex);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		phase_step <= stp;
		bend_amount <= bnd;
		fold_exponent <= fex;
		sample_queue.push_back(osc_sample(stp, bnd, fex));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sample_queue.size() != 0) @(posedge clk);
	endtask

	task automatic send_random(int n);
		logic [15:0] bnd, fex;
		for (int i = 0; i < n; i++) begin
			bnd = ($urandom_range(3) == 0) ? 16'(($urandom_range(1) != 0) ? 16'hFFFF : 0)
				: 16'($urandom);
			fex = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(40960));
			send_tick(31'($urandom), bnd, fex);
		end
	endtask

	task automatic test_directed();
		send_tick('0, '0, '0);
		send_tick(31'h7FFFFFFF, 16'hFFFF, 16'd40960);
		send_tick(31'h40000000, 16'hFFFF, '0);
		send_tick(31'h40000000, '0, 16'hFFFF);
		send_tick(31'h20000000, 16'hFFFF, 16'd40960);
		send_tick(31'h20000000, 16'h8000, 16'd8192);
		send_tick(31'h1, 16'hFFFF, 16'hFFFF);
		send_tick(31'h55555555, 16'h5555, 16'hAAAA);
		send_tick(31'h2AAAAAAA, 16'hAAAA, 16'h5555);
		send_tick(31'h10000000, 16'h0001, 16'd20480);
		send_tick(31'h7FFFFFFF, 16'hFFFE, 16'd40959);
		send_tick(31'h00000000, 16'h7FFF, 16'd1);
		// sender holds back until every expected sample has been received
		drain();
	endtask

	task automatic test_idle_phases();
		int sp[4] = '{0, 62, 0, 17};
		int rp[4] = '{0, 0, 62, 17};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = sp[ph];
			stall_pct = rp[ph];
			send_random(490);
		end
		send_idle_pct = 0;
		stall_pct = 0;
		drain();
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (out_valid && !out_stall) begin
			samples_seen <= samples_seen + 1;
			if (sample_queue.size() == 0) begin
				$error("sample transfer with nothing expected: %0d", sample);
				errors++;
			end else begin
				if (sample !== sample_queue[0]) begin
					$error("sample: expected %0d, actual %0d", sample_queue[0], sample);
					errors++;
				end
				void'(sample_queue.pop_front());
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("timeout with %0d samples pending", sample_queue.size());
			$display("FAIL phase_shaped_fold_oscillator");
			$finish;
		end
	end

	initial begin
		osc_phase = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idle_phases();
		repeat (200) @(posedge clk);
		$display("%0d ticks sent, %0d samples checked across four idle and stall mixes",
			items_sent, samples_seen);
		if (errors == 0 && sample_queue.size() == 0) begin
			$display("PASS phase_shaped_fold_oscillator");
		end else begin
			$display("FAIL phase_shaped_fold_oscillator");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/psfo_pkg.sv
design/psfo_div.sv
design/psfo_dp.sv
design/psfo_ctrl.sv
design/phase_shaped_fold_oscillator.sv
test/testbench.sv
